/* rtl/ceq_pkg.sv */
package ceq_pkg;

    localparam int QD     = 16;
    localparam int IDX_W  = $clog2(QD);
    localparam int CNT_W  = $clog2(QD + 1);
    localparam int TYPE_W = 5;
    localparam int NTYPES = 1 << TYPE_W;
    localparam int PAY_W  = 32;
    localparam int STAT_W = 32;
    localparam int LIM_W  = 6;
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(32);

    typedef enum logic [1:0] {
        K_POST  = 2'd0,
        K_POP   = 2'd1,
        K_CLEAR = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_CRIT  = 2'd0,
        REG_COAL  = 2'd1,
        REG_LOW   = 2'd2,
        REG_LIMIT = 2'd3
    } t_reg_idx;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [NTYPES-1:0] crit;
        logic [NTYPES-1:0] coal;
        logic [NTYPES-1:0] low;
        logic [LIM_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic load_new;
        logic load_pay;
    } t_cell_ctl;

    typedef struct packed {
        logic match;
        logic low;
        logic evm;
    } t_cell_flags;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
        sat_inc = (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
    endfunction

endpackage

/* rtl/ceq_if.sv */
interface ceq_in_if;
    import ceq_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [TYPE_W-1:0] event_type;
    logic [PAY_W-1:0]  event_payload;

    modport source (output valid, output kind, output event_type, output event_payload,
                    input ready);
    modport sink   (input valid, input kind, input event_type, input event_payload,
                    output ready);
endinterface

interface ceq_out_if;
    import ceq_pkg::*;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [TYPE_W-1:0] out_type;
    logic [PAY_W-1:0]  out_payload;
    logic [CNT_W-1:0]  queue_count;
    logic [CNT_W-1:0]  peak_level;
    logic              overflow_latched;
    logic [STAT_W-1:0] post_total;
    logic [STAT_W-1:0] merge_total;
    logic [STAT_W-1:0] evict_total;
    logic [STAT_W-1:0] drop_total;
    logic [STAT_W-1:0] critical_drop_count;

    modport source (output valid, output ok, output out_type, output out_payload,
                    output queue_count, output peak_level, output overflow_latched,
                    output post_total, output merge_total, output evict_total,
                    output drop_total, output critical_drop_count, input ready);
    modport sink   (input valid, input ok, input out_type, input out_payload,
                    input queue_count, input peak_level, input overflow_latched,
                    input post_total, input merge_total, input evict_total,
                    input drop_total, input critical_drop_count, output ready);
endinterface

/* rtl/ceq_regs.sv */
module ceq_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ceq_pkg::APB_AW-1:0] paddr,
    input  logic [ceq_pkg::APB_DW-1:0] pwdata,
    output logic [ceq_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output ceq_pkg::t_cfg              o_cfg
);
    import ceq_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_CRIT:  n_cfg.crit  = pwdata[NTYPES-1:0];
                REG_COAL:  n_cfg.coal  = pwdata[NTYPES-1:0];
                REG_LOW:   n_cfg.low   = pwdata[NTYPES-1:0];
                REG_LIMIT: n_cfg.limit = pwdata[LIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CRIT:  prdata = APB_DW'(r_cfg.crit);
            REG_COAL:  prdata = APB_DW'(r_cfg.coal);
            REG_LOW:   prdata = APB_DW'(r_cfg.low);
            REG_LIMIT: prdata = APB_DW'(r_cfg.limit);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crit  <= '0;
            r_cfg.coal  <= '0;
            r_cfg.low   <= '0;
            r_cfg.limit <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* rtl/ceq_cell.sv */
module ceq_cell (
    input  logic                       i_clk,
    input  ceq_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_valid,
    input  ceq_pkg::t_cfg              i_cfg,
    input  logic [ceq_pkg::TYPE_W-1:0] i_key_type,
    input  logic [ceq_pkg::PAY_W-1:0]  i_key_pay,
    input  logic [ceq_pkg::TYPE_W-1:0] i_nbr_type,
    input  logic [ceq_pkg::PAY_W-1:0]  i_nbr_pay,
    output logic [ceq_pkg::TYPE_W-1:0] o_type,
    output logic [ceq_pkg::PAY_W-1:0]  o_pay,
    output ceq_pkg::t_cell_flags       o_flags
);
    import ceq_pkg::*;

    logic [TYPE_W-1:0] r_type;
    logic [TYPE_W-1:0] n_type;
    logic [PAY_W-1:0]  r_pay;
    logic [PAY_W-1:0]  n_pay;
    logic              w_crit;
    logic              w_coal;
    logic              w_low;

    assign w_crit = i_cfg.crit[r_type];
    assign w_coal = i_cfg.coal[r_type];
    assign w_low  = i_cfg.low[r_type];

    assign o_flags.match = i_valid && (r_type == i_key_type);
    assign o_flags.low   = i_valid && !w_crit && !w_coal && w_low;
    assign o_flags.evm   = i_valid && !w_crit && w_coal;
    assign o_type        = r_type;
    assign o_pay         = r_pay;

    always_comb begin
        n_type = r_type;
        n_pay  = r_pay;
        priority if (i_ctl.load_new) begin
            n_type = i_key_type;
            n_pay  = i_key_pay;
        end else if (i_ctl.shift) begin
            n_type = i_nbr_type;
            n_pay  = i_nbr_pay;
        end else if (i_ctl.load_pay) begin
            n_pay  = i_key_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_pay  <= n_pay;
    end

endmodule

/* rtl/coalescing_event_queue_with_eviction_top.sv */
// An accepted beat is registered, decided in the decision state, and its result is registered.
// A new beat is accepted only after that decision, which waits while a result is not taken.
// The queue is a row of sixteen cells that shift toward the head on pop or eviction.
// Results wait in an output register, so the next beat is accepted while one is pending.
// Reset (synchronous, active low) clears occupancy, statistics, latch and class registers;
// the limit register returns to its reset value. Queue contents are not cleared by reset.
module coalescing_event_queue_with_eviction_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ceq_in_if.sink                     i_evt,
    ceq_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ceq_pkg::APB_AW-1:0] paddr,
    input  logic [ceq_pkg::APB_DW-1:0] pwdata,
    output logic [ceq_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import ceq_pkg::*;

    t_cfg              w_cfg;
    t_state            r_state;
    t_state            n_state;
    logic              w_go;

    logic [1:0]        r_kind;
    logic [TYPE_W-1:0] r_type;
    logic [PAY_W-1:0]  r_pay;

    logic [CNT_W-1:0]  r_occ,  n_occ;
    logic [CNT_W-1:0]  r_peak, n_peak;
    logic              r_latch, n_latch;
    logic [STAT_W-1:0] r_posted, n_posted;
    logic [STAT_W-1:0] r_merged, n_merged;
    logic [STAT_W-1:0] r_evict,  n_evict;
    logic [STAT_W-1:0] r_drop,   n_drop;
    logic [STAT_W-1:0] r_cdrop,  n_cdrop;

    logic              r_out_valid, n_out_valid;
    logic              r_ok,        n_ok;
    logic [TYPE_W-1:0] r_otype,     n_otype;
    logic [PAY_W-1:0]  r_opay,      n_opay;

    logic [TYPE_W-1:0] w_type [QD];
    logic [PAY_W-1:0]  w_pay  [QD];
    t_cell_flags       w_flags [QD];
    t_cell_ctl         w_ctl  [QD];
    logic [QD-1:0]     w_valid;
    logic [QD-1:0]     w_match;
    logic [QD-1:0]     w_lowv;
    logic [QD-1:0]     w_evmv;

    logic [QD-1:0]     w_match_oh;
    logic [QD-1:0]     w_vict;
    logic [QD-1:0]     w_vict_oh;
    logic [QD-1:0]     w_tail_oh;
    logic [QD-1:0]     v_shift;
    logic [QD-1:0]     v_load_new;
    logic [QD-1:0]     v_load_pay;

    logic              w_type_ok;
    logic              w_crit_t;
    logic              w_coal_t;
    logic              w_low_t;
    logic              w_cls_coal;
    logic              w_cls_norm;
    logic              w_full;

    ceq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    for (genvar i = 0; i < QD; i++) begin : g_cell
        logic [TYPE_W-1:0] w_nbr_type;
        logic [PAY_W-1:0]  w_nbr_pay;

        if (i == QD - 1) begin : g_last
            assign w_nbr_type = w_type[i];
            assign w_nbr_pay  = w_pay[i];
        end else begin : g_mid
            assign w_nbr_type = w_type[i+1];
            assign w_nbr_pay  = w_pay[i+1];
        end

        assign w_valid[i]  = CNT_W'(i) < r_occ;
        assign w_match[i]  = w_flags[i].match;
        assign w_lowv[i]   = w_flags[i].low;
        assign w_evmv[i]   = w_flags[i].evm;
        assign w_ctl[i]    = '{shift: v_shift[i], load_new: v_load_new[i],
                               load_pay: v_load_pay[i]};

        ceq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[i]),
            .i_valid    (w_valid[i]),
            .i_cfg      (w_cfg),
            .i_key_type (r_type),
            .i_key_pay  (r_pay),
            .i_nbr_type (w_nbr_type),
            .i_nbr_pay  (w_nbr_pay),
            .o_type     (w_type[i]),
            .o_pay      (w_pay[i]),
            .o_flags    (w_flags[i])
        );
    end

    assign i_evt.ready = (r_state == S_IDLE);

    assign o_res.valid               = r_out_valid;
    assign o_res.ok                  = r_ok;
    assign o_res.out_type            = r_otype;
    assign o_res.out_payload         = r_opay;
    assign o_res.queue_count         = r_occ;
    assign o_res.peak_level          = r_peak;
    assign o_res.overflow_latched    = r_latch;
    assign o_res.post_total          = r_posted;
    assign o_res.merge_total         = r_merged;
    assign o_res.evict_total         = r_evict;
    assign o_res.drop_total          = r_drop;
    assign o_res.critical_drop_count = r_cdrop;

    assign w_type_ok  = (r_type != '0) && ({1'b0, r_type} < w_cfg.limit);
    assign w_crit_t   = w_cfg.crit[r_type];
    assign w_coal_t   = w_cfg.coal[r_type];
    assign w_low_t    = w_cfg.low[r_type];
    assign w_cls_coal = !w_crit_t && w_coal_t;
    assign w_cls_norm = !w_crit_t && !w_coal_t && !w_low_t;
    assign w_full     = (r_occ == CNT_W'(QD));

    assign w_match_oh = w_match & (~w_match + QD'(1));
    assign w_vict_oh  = w_vict & (~w_vict + QD'(1));
    assign w_tail_oh  = QD'(1) << r_occ[IDX_W-1:0];

    always_comb begin
        priority if (w_crit_t) begin
            w_vict = (|w_lowv) ? w_lowv : w_evmv;
        end else if (w_cls_coal) begin
            w_vict = w_evmv;
        end else if (w_cls_norm) begin
            w_vict = w_lowv;
        end else begin
            w_vict = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        w_go    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_evt.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || o_res.ready) begin
                    w_go    = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_occ       = r_occ;
        n_peak      = r_peak;
        n_latch     = r_latch;
        n_posted    = r_posted;
        n_merged    = r_merged;
        n_evict     = r_evict;
        n_drop      = r_drop;
        n_cdrop     = r_cdrop;
        n_out_valid = r_out_valid && !o_res.ready;
        n_ok        = r_ok;
        n_otype     = r_otype;
        n_opay      = r_opay;
        v_shift     = '0;
        v_load_new  = '0;
        v_load_pay  = '0;
        if (w_go) begin
            n_out_valid = 1'b1;
            n_ok        = 1'b0;
            n_otype     = '0;
            n_opay      = '0;
            unique case (t_kind'(r_kind))
                K_POST: begin
                    if (!w_type_ok) begin
                        n_ok = 1'b0;
                    end else if (w_coal_t && (|w_match)) begin
                        v_load_pay = w_match_oh;
                        n_merged   = sat_inc(r_merged);
                        n_ok       = 1'b1;
                    end else if (!w_full) begin
                        v_load_new = w_tail_oh;
                        n_occ      = r_occ + CNT_W'(1);
                        n_posted   = sat_inc(r_posted);
                        n_ok       = 1'b1;
                        if (n_occ > r_peak) begin
                            n_peak = n_occ;
                        end
                    end else if (|w_vict) begin
                        v_shift            = ~(w_vict_oh - QD'(1));
                        v_load_new[QD-1]   = 1'b1;
                        n_evict            = sat_inc(r_evict);
                        n_posted           = sat_inc(r_posted);
                        n_ok               = 1'b1;
                    end else begin
                        n_drop = sat_inc(r_drop);
                        if (w_crit_t) begin
                            n_latch = 1'b1;
                            n_cdrop = sat_inc(r_cdrop);
                        end
                    end
                end
                K_POP: begin
                    if (r_occ != '0) begin
                        v_shift = '1;
                        n_occ   = r_occ - CNT_W'(1);
                        n_ok    = 1'b1;
                        n_otype = w_type[0];
                        n_opay  = w_pay[0];
                    end
                end
                K_CLEAR: begin
                    n_latch = 1'b0;
                end
                K_NOP: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_kind <= i_evt.kind;
            r_type <= i_evt.event_type;
            r_pay  <= i_evt.event_payload;
        end
        r_ok    <= n_ok;
        r_otype <= n_otype;
        r_opay  <= n_opay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_peak      <= '0;
            r_latch     <= 1'b0;
            r_posted    <= '0;
            r_merged    <= '0;
            r_evict     <= '0;
            r_drop      <= '0;
            r_cdrop     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ       <= n_occ;
            r_peak      <= n_peak;
            r_latch     <= n_latch;
            r_posted    <= n_posted;
            r_merged    <= n_merged;
            r_evict     <= n_evict;
            r_drop      <= n_drop;
            r_cdrop     <= n_cdrop;
            r_out_valid <= n_out_valid;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QD))
        else $error("Queue occupancy exceeds its depth.");

    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_occ)
        else $error("Peak occupancy is below current occupancy.");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("A result beat appeared without a decision cycle.");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_occ))
        else $error("Occupancy changed outside a decision cycle.");

    a_cdrop_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cdrop != $past(r_cdrop)) |-> r_latch)
        else $error("Critical drop counted without setting the latch.");

endmodule

/* tb/coalescing_event_queue_with_eviction_top_tb.sv */
`timescale 1ns / 1ps

module coalescing_event_queue_with_eviction_top_tb;
    import ceq_pkg::*;

    typedef enum logic [1:0] {
        CL_LOW,
        CL_NORMAL,
        CL_COAL,
        CL_CRIT
    } t_evt_class;

    typedef struct packed {
        logic              ok;
        logic [TYPE_W-1:0] ev_type;
        logic [PAY_W-1:0]  ev_pay;
        logic [CNT_W-1:0]  depth;
        logic [CNT_W-1:0]  peak;
        logic              latch;
        logic [STAT_W-1:0] posted;
        logic [STAT_W-1:0] merged;
        logic [STAT_W-1:0] evicted;
        logic [STAT_W-1:0] dropped;
        logic [STAT_W-1:0] crit_dropped;
    } t_result;

    typedef struct {
        bit                is_cfg;
        t_reg_idx          reg_idx;
        logic [31:0]       reg_val;
        t_kind             kind;
        logic [TYPE_W-1:0] ev_type;
        logic [PAY_W-1:0]  ev_pay;
        int                rep;
        bit                pinned;
        t_result           pin;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ceq_in_if  evt ();
    ceq_out_if res ();

    coalescing_event_queue_with_eviction_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the queue, its statistics and the class registers.
    logic [TYPE_W-1:0] mdl_type [QD];
    logic [PAY_W-1:0]  mdl_pay  [QD];
    int                mdl_occ;
    int                mdl_peak;
    logic              mdl_latch;
    logic [STAT_W-1:0] mdl_posted;
    logic [STAT_W-1:0] mdl_merged;
    logic [STAT_W-1:0] mdl_evicted;
    logic [STAT_W-1:0] mdl_dropped;
    logic [STAT_W-1:0] mdl_crit_dropped;
    logic [NTYPES-1:0] cfg_crit;
    logic [NTYPES-1:0] cfg_coal;
    logic [NTYPES-1:0] cfg_low;
    logic [LIM_W-1:0]  cfg_limit;

    t_result     outcome_q [$];
    t_stim_row   directed_tbl [$];
    int          fail_count;
    bit          steady;
    bit          hold_go;
    bit          rx_hold;
    t_result     seen_res;
    t_result     due_res;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [STAT_W-1:0] sat_bump(input logic [STAT_W-1:0] v);
        return (&v) ? v : v + STAT_W'(1);
    endfunction

    function automatic t_evt_class class_of(input logic [TYPE_W-1:0] t);
        if (cfg_crit[t]) return CL_CRIT;
        if (cfg_coal[t]) return CL_COAL;
        if (cfg_low[t]) return CL_LOW;
        return CL_NORMAL;
    endfunction

    function automatic int find_low_entry();
        for (int i = 0; i < mdl_occ; i++) begin
            if (class_of(mdl_type[i]) == CL_LOW) return i;
        end
        return -1;
    endfunction

    function automatic int find_merge_victim();
        for (int i = 0; i < mdl_occ; i++) begin
            if (!cfg_crit[mdl_type[i]] && cfg_coal[mdl_type[i]]) return i;
        end
        return -1;
    endfunction

    function automatic void remove_entry(input int idx);
        for (int i = idx; i + 1 < mdl_occ; i++) begin
            mdl_type[i] = mdl_type[i + 1];
            mdl_pay[i]  = mdl_pay[i + 1];
        end
        mdl_occ--;
    endfunction

    function automatic logic queue_post(input logic [TYPE_W-1:0] t, input logic [PAY_W-1:0] p);
        t_evt_class cls;
        int         victim;
        if (t == '0 || {1'b0, t} >= cfg_limit) return 1'b0;
        if (cfg_coal[t]) begin
            for (int i = 0; i < mdl_occ; i++) begin
                if (mdl_type[i] == t) begin
                    mdl_pay[i] = p;
                    mdl_merged = sat_bump(mdl_merged);
                    return 1'b1;
                end
            end
        end
        cls = class_of(t);
        victim = -1;
        if (mdl_occ >= QD) begin
            case (cls)
                CL_CRIT: begin
                    victim = find_low_entry();
                    if (victim < 0) victim = find_merge_victim();
                end
                CL_COAL: victim = find_merge_victim();
                CL_NORMAL: victim = find_low_entry();
                default: victim = -1;
            endcase
            if (victim >= 0) begin
                remove_entry(victim);
                mdl_evicted = sat_bump(mdl_evicted);
            end
            if (mdl_occ >= QD) begin
                mdl_dropped = sat_bump(mdl_dropped);
                if (cls == CL_CRIT) begin
                    mdl_latch = 1'b1;
                    mdl_crit_dropped = sat_bump(mdl_crit_dropped);
                end
                return 1'b0;
            end
        end
        mdl_type[mdl_occ] = t;
        mdl_pay[mdl_occ]  = p;
        mdl_occ++;
        mdl_posted = sat_bump(mdl_posted);
        if (mdl_occ > mdl_peak) mdl_peak = mdl_occ;
        return 1'b1;
    endfunction

    function automatic t_result predict_beat(input t_kind k, input logic [TYPE_W-1:0] t,
                                             input logic [PAY_W-1:0] p);
        t_result r;
        r = '0;
        case (k)
            K_POST: r.ok = queue_post(t, p);
            K_POP: begin
                if (mdl_occ > 0) begin
                    r.ev_type = mdl_type[0];
                    r.ev_pay  = mdl_pay[0];
                    remove_entry(0);
                    r.ok = 1'b1;
                end
            end
            K_CLEAR: mdl_latch = 1'b0;
            default: r.ok = 1'b0;
        endcase
        r.depth        = CNT_W'(mdl_occ);
        r.peak         = CNT_W'(mdl_peak);
        r.latch        = mdl_latch;
        r.posted       = mdl_posted;
        r.merged       = mdl_merged;
        r.evicted      = mdl_evicted;
        r.dropped      = mdl_dropped;
        r.crit_dropped = mdl_crit_dropped;
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf({"ok=%0d type=%0d payload=%h count=%0d peak=%0d latch=%0d ",
                          "posted=%0d merged=%0d evicted=%0d dropped=%0d crit_dropped=%0d"},
                         r.ok, r.ev_type, r.ev_pay, r.depth, r.peak, r.latch, r.posted,
                         r.merged, r.evicted, r.dropped, r.crit_dropped);
    endfunction

    function automatic t_stim_row cfg_row(input t_reg_idx idx, input logic [31:0] val);
        t_stim_row row;
        row = '{reg_idx: REG_CRIT, kind: K_POST, default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic t_stim_row beat_row(input t_kind k, input logic [TYPE_W-1:0] t,
                                           input logic [PAY_W-1:0] p, input int rep);
        t_stim_row row;
        row = '{reg_idx: REG_CRIT, kind: K_POST, default: '0};
        row.kind    = k;
        row.ev_type = t;
        row.ev_pay  = p;
        row.rep     = rep;
        return row;
    endfunction

    function automatic t_stim_row pinned_row(input t_kind k, input logic [TYPE_W-1:0] t,
                                             input logic [PAY_W-1:0] p, input logic ok,
                                             input logic [TYPE_W-1:0] otype,
                                             input logic [PAY_W-1:0] opay,
                                             input logic [CNT_W-1:0] depth);
        t_stim_row row;
        row = beat_row(k, t, p, 1);
        row.pinned      = 1'b1;
        row.pin.ok      = ok;
        row.pin.ev_type = otype;
        row.pin.ev_pay  = opay;
        row.pin.depth   = depth;
        return row;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_CRIT: cfg_crit = val;
            REG_COAL: cfg_coal = val;
            REG_LOW: cfg_low = val;
            default: cfg_limit = val[LIM_W-1:0];
        endcase
    endtask

    task automatic offer_beat(input t_kind k, input logic [TYPE_W-1:0] t,
                              input logic [PAY_W-1:0] p);
        evt.valid         <= 1'b1;
        evt.kind          <= k;
        evt.event_type    <= t;
        evt.event_payload <= p;
        @(posedge i_clk);
        while (!evt.ready) @(posedge i_clk);
        outcome_q.push_back(predict_beat(k, t, p));
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(0, 99) < 30) begin
            evt.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        evt.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res.ready <= !rx_hold && (steady || $urandom_range(0, 99) >= 24);
        end
    end

    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            seen_res.ok           = res.ok;
            seen_res.ev_type      = res.out_type;
            seen_res.ev_pay       = res.out_payload;
            seen_res.depth        = res.queue_count;
            seen_res.peak         = res.peak_level;
            seen_res.latch        = res.overflow_latched;
            seen_res.posted       = res.post_total;
            seen_res.merged       = res.merge_total;
            seen_res.evicted      = res.evict_total;
            seen_res.dropped      = res.drop_total;
            seen_res.crit_dropped = res.critical_drop_count;
            if (outcome_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("Result beat with none pending: %s", show(seen_res));
            end else begin
                due_res = outcome_q.pop_front();
                if (seen_res !== due_res) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("Mismatch, expected %s", show(due_res));
                        $display("           actual %s", show(seen_res));
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_stim_row         row;
        t_result           want;
        t_kind             kd;
        logic [TYPE_W-1:0] ty;
        logic [PAY_W-1:0]  pay;
        logic [31:0]       m_crit;
        logic [31:0]       m_coal;
        logic [31:0]       m_low;
        int                lim;
        int                n_items;
        int                pop_pct;
        int                pick;

        evt.valid         <= 1'b0;
        evt.kind          <= K_NOP;
        evt.event_type    <= '0;
        evt.event_payload <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_rst_n           <= 1'b0;
        fail_count = 0;
        steady     = 1'b0;
        hold_go    = 1'b0;
        mdl_occ          = 0;
        mdl_peak         = 0;
        mdl_latch        = 1'b0;
        mdl_posted       = '0;
        mdl_merged       = '0;
        mdl_evicted      = '0;
        mdl_dropped      = '0;
        mdl_crit_dropped = '0;
        cfg_crit  = '0;
        cfg_coal  = '0;
        cfg_low   = '0;
        cfg_limit = LIMIT_RESET;

        directed_tbl.push_back(pinned_row(K_POP, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0, 5'd0));
        directed_tbl.push_back(pinned_row(K_CLEAR, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0, 5'd0));
        directed_tbl.push_back(pinned_row(K_NOP, 5'd31, '1, 1'b0, 5'd0, 32'h0, 5'd0));
        directed_tbl.push_back(pinned_row(K_POST, 5'd0, '1, 1'b0, 5'd0, 32'h0, 5'd0));
        directed_tbl.push_back(pinned_row(K_POST, 5'd31, '1, 1'b1, 5'd0, 32'h0, 5'd1));
        directed_tbl.push_back(pinned_row(K_POST, 5'd1, 32'h0, 1'b1, 5'd0, 32'h0, 5'd2));
        directed_tbl.push_back(pinned_row(K_POP, 5'd0, 32'h0, 1'b1, 5'd31, '1, 5'd1));
        directed_tbl.push_back(pinned_row(K_POP, 5'd7, '1, 1'b1, 5'd1, 32'h0, 5'd0));
        // Types 2 and 3 critical (3 also merges), 4, 5 and 10 coalescible,
        // 6 and 7 low, everything else normal; types from 20 up are rejected.
        directed_tbl.push_back(cfg_row(REG_CRIT, 32'h0000_000C));
        directed_tbl.push_back(cfg_row(REG_COAL, 32'h0000_0438));
        directed_tbl.push_back(cfg_row(REG_LOW, 32'h0000_00C0));
        directed_tbl.push_back(cfg_row(REG_LIMIT, 32'd20));
        directed_tbl.push_back(pinned_row(K_POST, 5'd20, 32'h5A5A_5A5A, 1'b0, 5'd0, 32'h0, 5'd0));
        directed_tbl.push_back(beat_row(K_POST, 5'd19, 32'h1357_9BDF, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd4, 32'hA000_0001, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd3, 32'hC000_0001, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd3, 32'hC000_0002, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd4, 32'hA000_0002, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd6, 32'h6000_0000, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd5, 32'h5000_0000, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd8, 32'h8000_0000, 9));
        directed_tbl.push_back(beat_row(K_POST, 5'd7, 32'h7000_0000, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd8, 32'h8000_0100, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd2, 32'h2000_0001, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd8, 32'h8000_0200, 2));
        directed_tbl.push_back(beat_row(K_POST, 5'd6, 32'h6000_0001, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd10, 32'h1000_000A, 1));
        directed_tbl.push_back(beat_row(K_POST, 5'd2, 32'h2000_0002, 4));
        directed_tbl.push_back(beat_row(K_CLEAR, 5'd0, 32'h0, 1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_tbl[r]) begin
            row = directed_tbl[r];
            if (row.is_cfg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                for (int j = 0; j < row.rep; j++) begin
                    sender_gap();
                    offer_beat(row.kind, row.ev_type, row.ev_pay + PAY_W'(j));
                    if (row.pinned) begin
                        want = outcome_q.pop_back();
                        want.ok      = row.pin.ok;
                        want.ev_type = row.pin.ev_type;
                        want.ev_pay  = row.pin.ev_pay;
                        want.depth   = row.pin.depth;
                        outcome_q.push_back(want);
                    end
                end
            end
        end

        for (int ph = 0; ph < 10; ph++) begin
            settle();
            m_crit = $urandom & $urandom & $urandom;
            m_coal = $urandom;
            m_low  = $urandom;
            lim    = $urandom_range(2, 32);
            case (ph)
                0: begin
                    m_crit = '0;
                    m_coal = '0;
                    m_low  = '0;
                    lim    = 32;
                end
                1: begin
                    m_crit = '1;
                    m_coal = '1;
                    m_low  = '1;
                    lim    = 32;
                end
                2: lim = 1;
                8: lim = 2;
                default: ;
            endcase
            write_reg(REG_CRIT, m_crit);
            write_reg(REG_COAL, m_coal);
            write_reg(REG_LOW, m_low);
            write_reg(REG_LIMIT, 32'(lim));
            steady <= (ph == 3 || ph == 5);
            if (ph == 5) hold_go = 1'b1;
            n_items = (lim == 1) ? 40 : 190;
            pop_pct = $urandom_range(8, 45);
            for (int k = 0; k < n_items; k++) begin
                if (ph == 7 && k == n_items / 2) drain();
                sender_gap();
                pick = $urandom_range(0, 9);
                pay  = (pick == 0) ? '0 : (pick == 1) ? '1 : PAY_W'($urandom);
                ty   = TYPE_W'($urandom_range(0, 31));
                pick = $urandom_range(0, 99);
                if (pick < pop_pct) begin
                    kd = K_POP;
                end else if (pick < pop_pct + 4) begin
                    kd = K_CLEAR;
                end else if (pick < pop_pct + 7) begin
                    kd = K_NOP;
                end else begin
                    kd = K_POST;
                    if ($urandom_range(0, 99) < 6) begin
                        if (lim <= 31 && $urandom_range(0, 1) == 1) begin
                            ty = TYPE_W'($urandom_range(lim, 31));
                        end else begin
                            ty = '0;
                        end
                    end else begin
                        ty = (lim > 1) ? TYPE_W'($urandom_range(1, lim - 1)) : '0;
                    end
                end
                offer_beat(kd, ty, pay);
            end
            steady <= 1'b0;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && outcome_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ceq_pkg.sv
rtl/ceq_if.sv
rtl/ceq_regs.sv
rtl/ceq_cell.sv
rtl/coalescing_event_queue_with_eviction_top.sv
tb/coalescing_event_queue_with_eviction_top_tb.sv
